[rtl/dlp_pkg.sv]
// Package for the decimal literal parser: parse phases, character codes,
// keyword patterns, field widths and the finish-stage record.
// Depends on nothing; imported by decimal_literal_parser_top.
`default_nettype none

package dlp_pkg;

  // Widths and limits of the parsed fields.
  localparam int MaxDigits = 18;
  localparam int ExpWidth  = 32;
  localparam int CoefW     = 60;
  localparam int OutExpW   = 32;
  localparam int CountW    = $clog2(MaxDigits + 2);
  localparam int ExpMagW   = ExpWidth + 1;
  localparam int IndexW    = 6;
  localparam int KwBytes   = 8;

  localparam logic [ExpMagW-1:0] ExpNegLim = ExpMagW'(1) << (ExpWidth - 1);
  localparam logic [ExpMagW-1:0] ExpPosLim = ExpNegLim - ExpMagW'(1);

  // Stream payload widths.
  localparam int InDataW  = 8;
  localparam int OutDataW = 96;
  localparam int OutUserW = 4;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_ELEAD = 3'd3,
    PH_ESIGN = 3'd4,
    PH_ENUM  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PINF = 3'd1,
    KIND_MINF = 3'd2,
    KIND_NAN  = 3'd3,
    KIND_SNAN = 3'd4
  } kind_e;

  // Character codes.
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChCase  = 8'h20;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Lower-cased keywords, first character in the lowest byte.
  localparam logic [63:0] KwInf      = 64'h0000_0000_0066_6E69;
  localparam logic [63:0] KwInfinity = 64'h7974_696E_6966_6E69;
  localparam logic [63:0] KwNan      = 64'h0000_0000_006E_616E;
  localparam logic [63:0] KwSnan     = 64'h0000_0000_6E61_6E73;

  // State of a finished literal, handed to the result stage.
  typedef struct packed {
    logic                kw_inf;
    logic                kw_nan;
    logic                kw_snan;
    logic                shape_ok;
    logic                sign_neg;
    logic                exp_neg;
    logic [CoefW-1:0]    coef;
    logic [ExpWidth-1:0] exp_mag;
    logic [CountW-1:0]   frac_cnt;
  } fin_t;

endpackage

`default_nettype wire

[rtl/decimal_literal_parser_top.sv]
// Decimal literal parser: one character per request in, one result request
// per literal out. Depends on dlp_pkg for types, codes and widths.
`default_nettype none

//  Channel  Direction  tdata                              tuser             tlast
//  s_axis   in         [7:0] character                    -                 last
//  m_axis   out        [0] valid_res [1] negative         [0] spec_flag     -
//                      [61:2] coefficient [93:62] exponent [3:1] spec_kind
//
// One character is taken in every cycle while s_axis_tready is high. The scan
// state of a literal is folded into a finish register on its last character
// and the sign, range and keyword checks run from there into the output
// register. Reset clears the scan state and both stage valids.
// A stalled output holds its request; the input then stalls once the finish
// register is also full.
module decimal_literal_parser_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [dlp_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] character
  input  wire                          s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [dlp_pkg::OutDataW-1:0] m_axis_tdata,   // valid_res, negative,
                                                       // coefficient, exponent
  output logic [dlp_pkg::OutUserW-1:0] m_axis_tuser    // spec_flag, spec_kind
);
  import dlp_pkg::*;

  // Scan state.
  phase_e                phase_q, phase_d;
  logic [IndexW-1:0]     idx_q, idx_d;
  logic                  sign_q, sign_d;
  logic [CoefW-1:0]      coef_q, coef_d;
  logic [CountW-1:0]     dcnt_q, dcnt_d;
  logic [CountW-1:0]     fcnt_q, fcnt_d;
  logic                  eneg_q, eneg_d;
  logic [ExpWidth-1:0]   emag_q, emag_d;
  logic [KwBytes-1:0][7:0] kw_q, kw_d;
  logic                  err_q, err_d;

  // Finish and output stages.
  fin_t                  fin_q, fin_d;
  logic                  fin_vld_q;
  logic                  out_vld_q;
  logic [OutDataW-1:0]   out_data_q, out_data_d;
  logic [OutUserW-1:0]   out_user_q, out_user_d;

  logic                  out_free, fin_free, in_acc, fin_load;
  logic [7:0]            ch, lc;
  logic [3:0]            dig;
  logic                  is_dig, is_spc;
  phase_e                ph;
  logic [CoefW+3:0]      coef_x10;
  logic [ExpWidth+3:0]   emag_x10;
  logic [ExpWidth-1:0]   emag_next;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign fin_free      = !fin_vld_q || out_free;
  assign s_axis_tready = fin_free;
  assign in_acc        = s_axis_tvalid && fin_free;
  assign fin_load      = in_acc && s_axis_tlast;

  assign ch     = s_axis_tdata[7:0];
  assign lc     = (ch >= ChUpA && ch <= ChUpZ) ? (ch | ChCase) : ch;
  assign is_dig = (ch >= ChZero) && (ch <= ChNine);
  assign is_spc = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
  assign dig    = 4'(ch - ChZero);

  // Times ten as shifts and adds; the exponent magnitude saturates at all ones,
  // which is already beyond any exponent the range check lets through.
  assign coef_x10  = {coef_q, 3'b000} + {2'b00, coef_q, 1'b0} + (CoefW+4)'(dig);
  assign emag_x10  = {emag_q, 3'b000} + {2'b00, emag_q, 1'b0} + (ExpWidth+4)'(dig);
  assign emag_next = (emag_x10[ExpWidth+3:ExpWidth] != 4'd0) ? '1 : emag_x10[ExpWidth-1:0];

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sign_d  = sign_q;
    coef_d  = coef_q;
    dcnt_d  = dcnt_q;
    fcnt_d  = fcnt_q;
    eneg_d  = eneg_q;
    emag_d  = emag_q;
    kw_d    = kw_q;
    err_d   = err_q;
    ph      = (phase_q == PH_START) ? PH_INT : phase_q;
    fin_d   = fin_q;

    if (in_acc) begin
      if (phase_q == PH_START && (ch == ChPlus || ch == ChMinus)) begin
        phase_d = PH_INT;
        sign_d  = (ch == ChMinus);
      end else begin
        phase_d = ph;
        if (idx_q < IndexW'(KwBytes)) begin
          kw_d[idx_q[$clog2(KwBytes)-1:0]] = lc;
        end
        if (idx_q != '1) begin
          idx_d = idx_q + IndexW'(1);
        end
        unique case (ph)
          PH_INT, PH_FRAC: begin
            if (is_dig) begin
              if (dcnt_q < CountW'(MaxDigits)) begin
                coef_d = coef_x10[CoefW-1:0];
              end
              if (dcnt_q <= CountW'(MaxDigits)) begin
                dcnt_d = dcnt_q + CountW'(1);
              end
              if (ph == PH_FRAC && fcnt_q <= CountW'(MaxDigits)) begin
                fcnt_d = fcnt_q + CountW'(1);
              end
            end else if (ch == ChDot && ph == PH_INT) begin
              phase_d = PH_FRAC;
            end else if (ch == ChLowE || ch == ChUpE) begin
              phase_d = PH_ELEAD;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_ELEAD: begin
            if (is_spc) begin
              phase_d = PH_ELEAD;
            end else if (ch == ChPlus || ch == ChMinus) begin
              eneg_d  = (ch == ChMinus);
              phase_d = PH_ESIGN;
            end else if (is_dig) begin
              emag_d  = emag_next;
              phase_d = PH_ENUM;
            end else begin
              err_d = 1'b1;
            end
          end
          default: begin
            if (is_dig) begin
              emag_d  = emag_next;
              phase_d = PH_ENUM;
            end else begin
              err_d = 1'b1;
            end
          end
        endcase
      end

      if (s_axis_tlast) begin
        fin_d.kw_inf   = (idx_d == IndexW'(3) && kw_d == KwInf) ||
                         (idx_d == IndexW'(8) && kw_d == KwInfinity);
        fin_d.kw_nan   = (idx_d == IndexW'(3) && kw_d == KwNan);
        fin_d.kw_snan  = (idx_d == IndexW'(4) && kw_d == KwSnan);
        fin_d.shape_ok = !err_d && dcnt_d != '0 && dcnt_d <= CountW'(MaxDigits) &&
                         phase_d != PH_ELEAD && phase_d != PH_ESIGN;
        fin_d.sign_neg = sign_d;
        fin_d.exp_neg  = eneg_d;
        fin_d.coef     = coef_d;
        fin_d.exp_mag  = emag_d;
        fin_d.frac_cnt = fcnt_d;
        // The next literal starts from a clean scan state.
        phase_d = PH_START;
        idx_d   = '0;
        sign_d  = 1'b0;
        coef_d  = '0;
        dcnt_d  = '0;
        fcnt_d  = '0;
        eneg_d  = 1'b0;
        emag_d  = '0;
        kw_d    = '0;
        err_d   = 1'b0;
      end
    end
  end

  // Result stage: keyword priority, then shape, exponent range and sign.
  logic [ExpMagW-1:0] em_x, fr_x, mag;
  logic               mag_ok, val_neg;
  logic [63:0]        val64;
  logic               r_valid, r_neg, r_spec;
  kind_e              r_kind;
  logic [CoefW-1:0]   r_coef;
  logic [OutExpW-1:0] r_exp;

  always_comb begin
    em_x = ExpMagW'(fin_q.exp_mag);
    fr_x = ExpMagW'(fin_q.frac_cnt);
    priority if (fin_q.exp_neg) begin
      mag     = em_x + fr_x;
      mag_ok  = (mag <= ExpNegLim);
      val_neg = 1'b1;
    end else if (em_x >= fr_x) begin
      mag     = em_x - fr_x;
      mag_ok  = (mag <= ExpPosLim);
      val_neg = 1'b0;
    end else begin
      mag     = fr_x - em_x;
      mag_ok  = (mag <= ExpNegLim);
      val_neg = 1'b1;
    end
    val64 = val_neg ? (64'd0 - 64'(mag)) : 64'(mag);

    r_valid = 1'b0;
    r_neg   = 1'b0;
    r_spec  = 1'b0;
    r_kind  = KIND_NONE;
    r_coef  = '0;
    r_exp   = '0;
    priority if (fin_q.kw_inf) begin
      r_valid = 1'b1;
      r_spec  = 1'b1;
      r_neg   = fin_q.sign_neg;
      r_kind  = fin_q.sign_neg ? KIND_MINF : KIND_PINF;
    end else if (fin_q.kw_nan) begin
      r_valid = 1'b1;
      r_spec  = 1'b1;
      r_neg   = fin_q.sign_neg;
      r_kind  = KIND_NAN;
    end else if (fin_q.kw_snan) begin
      r_valid = 1'b1;
      r_spec  = 1'b1;
      r_neg   = fin_q.sign_neg;
      r_kind  = KIND_SNAN;
    end else if (fin_q.shape_ok && mag_ok) begin
      r_valid = 1'b1;
      r_neg   = fin_q.sign_neg;
      r_coef  = fin_q.coef;
      r_exp   = val64[OutExpW-1:0];
    end

    out_data_d = {2'b00, r_exp, r_coef, r_neg, r_valid};
    out_user_d = {r_kind, r_spec};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      idx_q   <= '0;
      sign_q  <= 1'b0;
      coef_q  <= '0;
      dcnt_q  <= '0;
      fcnt_q  <= '0;
      eneg_q  <= 1'b0;
      emag_q  <= '0;
      kw_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sign_q  <= sign_d;
      coef_q  <= coef_d;
      dcnt_q  <= dcnt_d;
      fcnt_q  <= fcnt_d;
      eneg_q  <= eneg_d;
      emag_q  <= emag_d;
      kw_q    <= kw_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fin_free) begin
        fin_vld_q <= fin_load;
      end
      if (out_free) begin
        out_vld_q <= fin_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_q <= fin_d;
    end
    if (out_free && fin_vld_q) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
